>>> rtl/bgte_pkg.sv
// shared constants and types for the bit-plane group-test encoder
`timescale 1ns / 1ps
`default_nettype none

package bgte_pkg;

	localparam int BLOCK_VALUES_DEF = 64;

	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = 6;
	localparam int COEFF_W     = 64;
	localparam int PLANE_W     = 6;

	localparam int CHUNK_W  = 64;
	localparam int CHUNK_IW = 6;
	localparam int CNT_W    = 7;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	// sequencer to bit packer
	typedef struct packed {
		logic put;
		logic bit_val;
		logic flush;
		logic done;
	} pack_ctl_t;

endpackage

`default_nettype wire

>>> rtl/bgte_store.sv
// coefficient store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bgte_store
	import bgte_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [STORE_AW-1:0] waddr,
	input  wire logic [COEFF_W-1:0]  wdata,
	input  wire logic [STORE_AW-1:0] raddr,
	output logic      [COEFF_W-1:0]  rdata_s1
);

	logic [COEFF_W-1:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/bgte_packer.sv
// packs the serial bit stream into 64-bit chunks and drives the result ports
`timescale 1ns / 1ps
`default_nettype none

module bgte_packer
	import bgte_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pack_ctl_t          ctl,
	output logic                    chunk_valid,
	output logic      [CHUNK_W-1:0] chunk_bits,
	output logic      [CNT_W-1:0]   chunk_count,
	output logic                    last_chunk,
	output logic                    block_done
);

	logic [CHUNK_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               full;

	assign full = (cnt_q == CNT_W'(CHUNK_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			chunk_valid <= 1'b0;
			chunk_bits  <= '0;
			chunk_count <= '0;
			last_chunk  <= 1'b0;
			block_done  <= 1'b0;
		end else begin
			chunk_valid <= 1'b0;
			if (ctl.put) begin
				if (full) begin
					// a further bit exists, so the full chunk is not the last one
					chunk_valid <= 1'b1;
					chunk_bits  <= acc_q;
					chunk_count <= cnt_q;
					last_chunk  <= 1'b0;
					block_done  <= ctl.done;
					acc_q       <= CHUNK_W'(ctl.bit_val);
					cnt_q       <= CNT_W'(1);
				end else begin
					acc_q <= acc_q | (CHUNK_W'(ctl.bit_val) << cnt_q[CHUNK_IW-1:0]);
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (ctl.flush) begin
				chunk_valid <= 1'b1;
				chunk_bits  <= acc_q;
				chunk_count <= cnt_q;
				last_chunk  <= 1'b1;
				block_done  <= ctl.done;
				acc_q       <= '0;
				cnt_q       <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/bitplane_group_test_encoder.sv
// top level of the embedded bit-plane group-test encoder
`timescale 1ns / 1ps
`default_nettype none

// Encodes one bit plane of a block of BLOCK_VALUES unsigned 64-bit
// coefficients, embedded-coder style. A transfer with opcode load writes one
// coefficient into the store and clears the significance count N; busy
// stays low. A transfer with opcode encode gathers the
// chosen bit of every coefficient into a plane word, sends the first N bits
// verbatim, then group-test bits: a 1 if any bit remains at or above N
// (a 0 ends the plane) followed by unary run bits up to the next set bit,
// the last position being implied. Results come out as chunks of up to 64
// bits, first bit in bit 0, each on the result ports for exactly one cycle
// with chunk_valid high; the receiver cannot stall them. last_chunk marks
// the final chunk, an all-zero plane with N = 0 gives one chunk of a single
// 0 bit, and block_done (same on every chunk) says all positions are now
// significant. An encode keeps busy high while it gathers the plane word,
// one store read per cycle through the registered read port, while it
// sends the verbatim bits, through a hand-over step, while it sends the
// group-test and run bits, through the states that send nothing when the
// runs reach the end (the implied last position and the closing test), and
// through a flush step. An encode emits at most 2 * BLOCK_VALUES - 1 bits.
// The last chunk is strobed in the same cycle in which busy first reads low.
// Entries of the store that were never loaded read as unknown.

module bitplane_group_test_encoder
	import bgte_pkg::*;
#(
	parameter int BLOCK_VALUES = BLOCK_VALUES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               opcode,
	input  wire logic [5:0]         coeff_index,
	input  wire logic [COEFF_W-1:0] coeff_value,
	input  wire logic [PLANE_W-1:0] plane,
	output logic                    chunk_valid,
	output logic      [CHUNK_W-1:0] chunk_bits,
	output logic      [CNT_W-1:0]   chunk_count,
	output logic                    last_chunk,
	output logic                    block_done
);

	// position counters must hold BLOCK_VALUES itself
	localparam int CW = $clog2(BLOCK_VALUES + 1);
	localparam logic [CW-1:0] BLK_CW  = CW'(BLOCK_VALUES);
	localparam logic [CW-1:0] LAST_CW = CW'(BLOCK_VALUES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATHER,
		ST_VERB,
		ST_TEST,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             gi_q;      // next store address to read
	logic                      vld_s1;    // store read data valid
	logic [PLANE_W-1:0]        plane_q;
	logic [BLOCK_VALUES-1:0]   x_q;       // plane word, shifted so bit 0 is position pos_q
	logic [CW-1:0]             pos_q;     // current position (running N)
	logic [CW-1:0]             n0_q;      // N at the start of the plane
	logic [CW-1:0]             count_q;   // significance count kept between planes
	logic                      done_q;
	logic [COEFF_W-1:0]        rdata_s1;
	logic                      load_we;
	pack_ctl_t                 pack_ctl;

	assign busy    = (state_q != ST_IDLE);
	assign load_we = start && !busy && (opcode == OP_LOAD);

	bgte_store u_store (
		.clk      (clk),
		.we       (load_we),
		.waddr    (coeff_index),
		.wdata    (coeff_value),
		.raddr    (STORE_AW'(gi_q)),
		.rdata_s1 (rdata_s1)
	);

	// bit emitted this cycle, straight from the sequencer state
	always_comb begin
		pack_ctl         = '0;
		pack_ctl.done    = done_q;
		pack_ctl.bit_val = x_q[0];
		unique case (state_q)
			ST_VERB: begin
				pack_ctl.put = (pos_q < n0_q);
			end
			ST_TEST: begin
				// group test: anything left at or above the current position
				pack_ctl.put     = (pos_q < BLK_CW);
				pack_ctl.bit_val = |x_q;
			end
			ST_RUN: begin
				// the last position is implied and never sent
				pack_ctl.put = (pos_q < LAST_CW);
			end
			ST_FLUSH: begin
				pack_ctl.flush = 1'b1;
			end
			default: begin
				pack_ctl.put = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gi_q    <= '0;
			vld_s1  <= 1'b0;
			plane_q <= '0;
			x_q     <= '0;
			pos_q   <= '0;
			n0_q    <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (opcode == OP_LOAD) begin
							count_q <= '0;
						end else begin
							plane_q <= plane;
							n0_q    <= (count_q > BLK_CW) ? BLK_CW : count_q;
							gi_q    <= '0;
							x_q     <= '0;
							state_q <= ST_GATHER;
						end
					end
				end
				ST_GATHER: begin
					// coefficient i lands in bit i after all shifts
					if (vld_s1) begin
						x_q <= {rdata_s1[plane_q], x_q[BLOCK_VALUES-1:1]};
					end
					if (gi_q < BLK_CW) begin
						gi_q   <= gi_q + CW'(1);
						vld_s1 <= 1'b1;
					end else if (!vld_s1) begin
						pos_q   <= '0;
						// full already, or top position set so the runs reach the end
						done_q  <= (n0_q == BLK_CW) || x_q[BLOCK_VALUES-1];
						state_q <= ST_VERB;
					end
				end
				ST_VERB: begin
					if (pos_q < n0_q) begin
						x_q   <= {1'b0, x_q[BLOCK_VALUES-1:1]};
						pos_q <= pos_q + CW'(1);
					end else begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if ((pos_q >= BLK_CW) || (x_q == '0)) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					x_q   <= {1'b0, x_q[BLOCK_VALUES-1:1]};
					pos_q <= pos_q + CW'(1);
					if ((pos_q >= LAST_CW) || x_q[0]) begin
						state_q <= ST_TEST;
					end
				end
				ST_FLUSH: begin
					count_q <= pos_q;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	bgte_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (pack_ctl),
		.chunk_valid (chunk_valid),
		.chunk_bits  (chunk_bits),
		.chunk_count (chunk_count),
		.last_chunk  (last_chunk),
		.block_done  (block_done)
	);

endmodule

`default_nettype wire
